// ===== rtl/base58_string_decoder_unit_assert.svh =====
// ----------------------------------------------------------------------------
// base58 string decoder assertion macros
// concurrent checks, clocked on the rising edge and idle while in reset
// ----------------------------------------------------------------------------
`ifndef BASE58_STRING_DECODER_UNIT_ASSERT_SVH
`define BASE58_STRING_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// check with an explicit clock and active-low reset
`define BSD_ASSERT_ON(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error("base58 decoder check failed");
// check on the local clk and rst_n
`define BSD_ASSERT(lbl, prop) `BSD_ASSERT_ON(lbl, clk, rst_n, prop)
`else
`define BSD_ASSERT_ON(lbl, ck, rn, prop)
`define BSD_ASSERT(lbl, prop)
`endif

`endif

// ===== rtl/bsd_pkg.sv =====
// ----------------------------------------------------------------------------
// bsd_pkg
// shared constants, types and the base58 alphabet map of the string decoder
// ----------------------------------------------------------------------------
`default_nettype none

package bsd_pkg;

    // default configuration
    localparam int OUT_BYTES_DEF   = 25;
    localparam int MIN_CHARS_DEF   = 5;
    localparam int MAX_CHARS_DEF   = 40;
    localparam int QUEUE_DEPTH_DEF = 2;

    // stream widths
    localparam int IN_DATA_W    = 8;
    localparam int OUT_DATA_W   = 16;
    localparam int BYTE_INDEX_W = 5;

    // exact code of a leading one character
    localparam logic [7:0] CHAR_ONE = 8'h31;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } digit_t;

    // bitcoin alphabet: 1-9 A-H J-N P-Z a-k m-z
    function automatic digit_t digit_of(input logic [6:0] c);
        digit_t d;
        d.valid = 1'b1;
        d.value = 6'd0;
        if (c >= 7'h31 && c <= 7'h39)
            d.value = 6'(c - 7'h31);
        else if (c >= 7'h41 && c <= 7'h48)
            d.value = 6'(c - 7'h41 + 7'd9);
        else if (c >= 7'h4A && c <= 7'h4E)
            d.value = 6'(c - 7'h4A + 7'd17);
        else if (c >= 7'h50 && c <= 7'h5A)
            d.value = 6'(c - 7'h50 + 7'd22);
        else if (c >= 7'h61 && c <= 7'h6B)
            d.value = 6'(c - 7'h61 + 7'd33);
        else if (c >= 7'h6D && c <= 7'h7A)
            d.value = 6'(c - 7'h6D + 7'd44);
        else
            d.valid = 1'b0;
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bsd_front.sv =====
// ----------------------------------------------------------------------------
// bsd_front
// takes characters, maps them to digits and folds them into a carry-save
// accumulator; the final state of each string is pushed as one record
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_front #(
    parameter int MAX_CHARS = 40,
    parameter int ACC_W     = 240,
    parameter int CNT_W     = 6
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  wire logic [bsd_pkg::IN_DATA_W-1:0]         s_axis_tdata,   // char_code[7:0]
    input  wire logic                                  s_axis_tlast,
    output logic                                       rec_push,
    output logic [2*ACC_W+2*CNT_W:0]                   rec_data,
    input  wire logic                                  rec_room
);
    import bsd_pkg::*;

    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(MAX_CHARS + 1);

    logic [ACC_W-1:0] sum_reg, sum_next;
    logic [ACC_W-1:0] cy_reg, cy_next;
    logic             bad_reg, bad_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] ones_reg, ones_next;
    logic             lead_reg, lead_next;

    logic             fire;
    digit_t           dig;
    logic [ACC_W-1:0] t0, t1, t2, t3, t4, t5;
    logic [ACC_W-1:0] s1, c1, s2, c2, s3, c3, s4, c4;

    assign s_axis_tready = rec_room;
    assign fire          = s_axis_tvalid && rec_room;
    assign dig           = digit_of(s_axis_tdata[6:0]);

    // acc * 58 + d as 64a - 8a + 2a on both carry-save halves, two +1s folded in
    always_comb
    begin
        t0 = (sum_reg << 6) | ACC_W'(dig.value);
        t1 = ~(sum_reg << 3);
        t2 = sum_reg << 1;
        t3 = (cy_reg << 6) | ACC_W'(2);
        t4 = ~(cy_reg << 3);
        t5 = cy_reg << 1;
        s1 = t0 ^ t1 ^ t2;
        c1 = ((t0 & t1) | (t0 & t2) | (t1 & t2)) << 1;
        s2 = t3 ^ t4 ^ t5;
        c2 = ((t3 & t4) | (t3 & t5) | (t4 & t5)) << 1;
        s3 = s1 ^ c1 ^ s2;
        c3 = ((s1 & c1) | (s1 & s2) | (c1 & s2)) << 1;
        s4 = s3 ^ c3 ^ c2;
        c4 = ((s3 & c3) | (s3 & c2) | (c3 & c2)) << 1;
    end

    // per-string counters and flags
    always_comb
    begin
        sum_next  = dig.valid ? s4 : sum_reg;
        cy_next   = dig.valid ? c4 : cy_reg;
        bad_next  = bad_reg || !dig.valid;
        cnt_next  = (cnt_reg < CNT_CAP) ? cnt_reg + CNT_W'(1) : cnt_reg;
        ones_next = ones_reg;
        lead_next = 1'b0;
        if (lead_reg && s_axis_tdata == CHAR_ONE)
        begin
            lead_next = 1'b1;
            if (ones_reg < CNT_CAP)
                ones_next = ones_reg + CNT_W'(1);
        end
    end

    // record of a finished string
    assign rec_push = fire && s_axis_tlast;
    assign rec_data = {ones_next, cnt_next, bad_next, cy_next, sum_next};

    // string state, cleared after the last character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            cy_reg   <= '0;
            bad_reg  <= 1'b0;
            cnt_reg  <= '0;
            ones_reg <= '0;
            lead_reg <= 1'b1;
        end
        else if (fire)
        begin
            if (s_axis_tlast)
            begin
                sum_reg  <= '0;
                cy_reg   <= '0;
                bad_reg  <= 1'b0;
                cnt_reg  <= '0;
                ones_reg <= '0;
                lead_reg <= 1'b1;
            end
            else
            begin
                sum_reg  <= sum_next;
                cy_reg   <= cy_next;
                bad_reg  <= bad_next;
                cnt_reg  <= cnt_next;
                ones_reg <= ones_next;
                lead_reg <= lead_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bsd_queue.sv =====
// ----------------------------------------------------------------------------
// bsd_queue
// short first-in first-out queue of string records between front and back
// ----------------------------------------------------------------------------
`default_nettype none

`include "base58_string_decoder_unit_assert.svh"

module bsd_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   room,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      head_data,
    output logic                   head_valid
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign room       = (count_reg != CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

    // pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    `BSD_ASSERT(a_count_bound, count_reg <= CNT_FULL)
    `BSD_ASSERT(a_no_push_full, push |-> count_reg < CNT_FULL)
    `BSD_ASSERT(a_no_pop_empty, pop |-> count_reg != '0)
    `BSD_ASSERT(a_count_tracks, (push && !pop) |=> count_reg == $past(count_reg) + CNT_W'(1))

endmodule

`default_nettype wire

// ===== rtl/bsd_back.sv =====
// ----------------------------------------------------------------------------
// bsd_back
// resolves a string record, checks it and sends the 25-byte result or a
// single failure result
// ----------------------------------------------------------------------------
`default_nettype none

`include "base58_string_decoder_unit_assert.svh"

module bsd_back #(
    parameter int OUT_BYTES = 25,
    parameter int MIN_CHARS = 5,
    parameter int MAX_CHARS = 40,
    parameter int ACC_W     = 240,
    parameter int CNT_W     = 6
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              rec_valid,
    output logic                                   rec_pop,
    input  wire logic [2*ACC_W+2*CNT_W:0]          rec_data,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [bsd_pkg::OUT_DATA_W-1:0]         m_axis_tdata,  // out_byte[7:0], byte_index[12:8]
    output logic                                   m_axis_tuser,  // ok
    output logic                                   m_axis_tlast
);
    import bsd_pkg::*;

    localparam int BYTE_W = 8 * OUT_BYTES;
    localparam int IDX_W  = (OUT_BYTES > 1) ? $clog2(OUT_BYTES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(OUT_BYTES - 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CHECK = 3'b010,
        ST_EMIT  = 3'b100
    } back_state_t;

    back_state_t      state_reg, state_next;
    logic [ACC_W-1:0] val_reg;
    logic             bad_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] ones_reg;
    logic             ok_reg;
    logic [IDX_W-1:0] idx_reg;

    logic [ACC_W-1:0] rec_sum, rec_cy;
    logic             rec_bad;
    logic [CNT_W-1:0] rec_cnt, rec_ones;
    logic             m_fire, m_last, load, check_ok;
    logic [7:0]       out_byte;

    // record fields
    assign rec_sum  = rec_data[ACC_W-1:0];
    assign rec_cy   = rec_data[2*ACC_W-1:ACC_W];
    assign rec_bad  = rec_data[2*ACC_W];
    assign rec_cnt  = rec_data[2*ACC_W+CNT_W:2*ACC_W+1];
    assign rec_ones = rec_data[2*ACC_W+2*CNT_W:2*ACC_W+CNT_W+1];

    // result handshake
    assign m_fire  = m_axis_tvalid && m_axis_tready;
    assign m_last  = !ok_reg || (idx_reg == IDX_LAST);
    assign load    = rec_valid && ((state_reg == ST_IDLE) ||
                                   (state_reg == ST_EMIT && m_fire && m_last));
    assign rec_pop = load;

    // validity: flags, length range, no overflow and ones plus significant bytes exact
    always_comb
    begin
        int ones_i;
        logic nz;
        ones_i   = int'(ones_reg);
        check_ok = !bad_reg && int'(cnt_reg) >= MIN_CHARS &&
                   int'(cnt_reg) <= MAX_CHARS &&
                   (val_reg[ACC_W-1:BYTE_W] == '0) && ones_i <= OUT_BYTES;
        for (int j = 0; j < OUT_BYTES; j++)
        begin
            nz = |val_reg[8*j +: 8];
            if (j + ones_i >= OUT_BYTES && nz)
                check_ok = 1'b0;
            if (j + ones_i == OUT_BYTES - 1 && !nz)
                check_ok = 1'b0;
        end
    end

    // sequencing
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (load)
                    state_next = ST_CHECK;
            ST_CHECK:
                state_next = ST_EMIT;
            ST_EMIT:
                if (m_fire && m_last)
                    state_next = load ? ST_CHECK : ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ok_reg    <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
                idx_reg <= '0;
            else if (m_fire && !m_last)
                idx_reg <= idx_reg + IDX_W'(1);
            if (state_reg == ST_CHECK)
                ok_reg <= check_ok;
        end
    end

    // resolved value, shifted out most significant byte first
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            val_reg  <= rec_sum + rec_cy;
            bad_reg  <= rec_bad;
            cnt_reg  <= rec_cnt;
            ones_reg <= rec_ones;
        end
        else if (m_fire && !m_last)
            val_reg <= val_reg << 8;
    end

    // result fields
    assign out_byte      = ok_reg ? val_reg[BYTE_W-1 -: 8] : 8'd0;
    assign m_axis_tvalid = (state_reg == ST_EMIT);
    assign m_axis_tdata  = {3'b000, BYTE_INDEX_W'(idx_reg), out_byte};
    assign m_axis_tuser  = ok_reg;
    assign m_axis_tlast  = m_last;

    `BSD_ASSERT(a_fail_index_zero, (m_axis_tvalid && !ok_reg) |-> idx_reg == '0)
    `BSD_ASSERT(a_index_bound, idx_reg <= IDX_LAST)
    `BSD_ASSERT(a_pop_has_data, rec_pop |-> rec_valid)
    `BSD_ASSERT(a_check_to_emit, (state_reg == ST_CHECK) |=> state_reg == ST_EMIT)
    `BSD_ASSERT(a_end_to_idle, (m_fire && m_last && !rec_valid) |=> state_reg == ST_IDLE)

endmodule

`default_nettype wire

// ===== rtl/base58_string_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// base58_string_decoder_unit
// base58 string to 25-byte big-endian decoder with length and size checks
// ----------------------------------------------------------------------------
//  channel   side     tdata                                  tuser   tlast
//  s_axis    input    char_code[7:0]                         -       last_char
//  m_axis    output   out_byte[7:0], byte_index[12:8]        ok      last_byte
//
//  one character is taken per cycle while the queue has room; the fold is a carry-save multiply-add
//  each string passes the result side through a check state and then OUT_BYTES
//  result bytes, or a single failure byte; the next string's load overlaps
//  the last result of the previous one
//  up to QUEUE_DEPTH finished strings wait between the two sides; the input
//  stalls only while that queue is full
//  asynchronous reset clears all string state at once, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module base58_string_decoder_unit #(
    parameter int OUT_BYTES   = bsd_pkg::OUT_BYTES_DEF,
    parameter int MIN_CHARS   = bsd_pkg::MIN_CHARS_DEF,
    parameter int MAX_CHARS   = bsd_pkg::MAX_CHARS_DEF,
    parameter int QUEUE_DEPTH = bsd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [bsd_pkg::IN_DATA_W-1:0] s_axis_tdata,   // char_code[7:0]
    input  wire logic                          s_axis_tlast,   // last_char
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [bsd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // out_byte[7:0], byte_index[12:8]
    output logic                               m_axis_tuser,   // ok
    output logic                               m_axis_tlast    // last_byte
);
    import bsd_pkg::*;

    // accumulator wide enough for MAX_CHARS digits and the overflow bit
    localparam int ACC_W = (6 * MAX_CHARS > 8 * OUT_BYTES) ? 6 * MAX_CHARS
                                                           : 8 * OUT_BYTES + 1;
    localparam int CNT_W = $clog2(MAX_CHARS + 2);
    localparam int REC_W = 2 * ACC_W + 2 * CNT_W + 1;

    logic             rec_push, rec_room, rec_pop, rec_valid;
    logic [REC_W-1:0] push_data, head_data;

    // character intake and accumulation
    bsd_front #(
        .MAX_CHARS (MAX_CHARS),
        .ACC_W     (ACC_W),
        .CNT_W     (CNT_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .rec_push      (rec_push),
        .rec_data      (push_data),
        .rec_room      (rec_room)
    );

    // finished strings awaiting output
    bsd_queue #(
        .DATA_W (REC_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (rec_push),
        .push_data  (push_data),
        .room       (rec_room),
        .pop        (rec_pop),
        .head_data  (head_data),
        .head_valid (rec_valid)
    );

    // checks and byte output
    bsd_back #(
        .OUT_BYTES (OUT_BYTES),
        .MIN_CHARS (MIN_CHARS),
        .MAX_CHARS (MAX_CHARS),
        .ACC_W     (ACC_W),
        .CNT_W     (CNT_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .rec_valid     (rec_valid),
        .rec_pop       (rec_pop),
        .rec_data      (head_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== tb/sv/base58_string_decoder_unit_test.sv =====
// ----------------------------------------------------------------------------
// base58_string_decoder_unit_test
// self-checking bench for the base58 string decoder: strings are built from
// random 25-byte values spelled in base58, then broken, padded or mixed with
// noise; a behavioural decoder predicts every byte and checks the output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module base58_string_decoder_unit_test;

    localparam int N_BYTES      = bsd_pkg::OUT_BYTES_DEF;
    localparam int MIN_LEN      = bsd_pkg::MIN_CHARS_DEF;
    localparam int MAX_LEN      = bsd_pkg::MAX_CHARS_DEF;
    localparam int COUNT_CAP    = MAX_LEN + 1;
    localparam int VALUE_W      = 8 * N_BYTES;
    localparam int REPORT_LIMIT = 10;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 2 * (N_BYTES + 2);
    // shortest run of non-leading digits that cannot fit in 25 bytes
    localparam int OVERFLOW_LEN = 36;
    // a one character with the top bit set: maps to zero, never a leading one
    localparam logic [7:0] ONE_WITH_HIGH_BIT = 8'hB1;
    localparam string B58_ALPHABET =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    typedef struct packed {
        logic [7:0] value;
        logic [4:0] index;
        logic       ok;
        logic       last;
    } byte_result_t;

    typedef enum {
        TXT_DECODABLE,
        TXT_NOISE,
        TXT_OVERFLOW,
        TXT_CORRUPT,
        TXT_HIGH_BIT,
        TXT_OVERLONG,
        TXT_RESHAPED
    } text_kind_e;

    // decoder model and store of bytes still to come
    class base58_board;
        byte_result_t expected_bytes[$];
        logic [7:0]   acc[N_BYTES];
        int unsigned  sig_count;
        int unsigned  n_chars;
        int unsigned  n_ones;
        bit           overflowed;
        bit           bad_seen;
        bit           in_prefix;
        int unsigned  mismatches;
        int unsigned  strings_done;
        int unsigned  decoded;
        int unsigned  rejected;

        function new();
            clear_string();
            mismatches   = 0;
            strings_done = 0;
            decoded      = 0;
            rejected     = 0;
        endfunction

        // digit value by alphabet search, -1 when the code is not a digit
        static function int digit_value(logic [6:0] c);
            for (int i = 0; i < 58; i++)
                if (B58_ALPHABET[i] == {1'b0, c})
                    return i;
            return -1;
        endfunction

        function void clear_string();
            foreach (acc[i])
                acc[i] = 8'h00;
            sig_count  = 0;
            n_chars    = 0;
            n_ones     = 0;
            overflowed = 1'b0;
            bad_seen   = 1'b0;
            in_prefix  = 1'b1;
        endfunction

        // add one predicted byte at the tail of the store
        function void add_expected(byte_result_t r);
            expected_bytes.insert(expected_bytes.size(), r);
        endfunction

        // acc = acc * 58 + digit, growing one byte at a time
        function void fold_digit(int unsigned d);
            int unsigned carry;
            carry = d;
            for (int j = 0; j < sig_count; j++)
            begin
                carry += 32'(acc[j]) * 58;
                acc[j] = 8'(carry);
                carry >>= 8;
            end
            while (carry != 0)
            begin
                if (sig_count < N_BYTES)
                begin
                    acc[sig_count] = 8'(carry);
                    sig_count++;
                end
                else
                    overflowed = 1'b1;
                carry >>= 8;
            end
        endfunction

        function void take_char(logic [7:0] code, logic last_flag);
            int           d;
            byte_result_t r;
            if (n_chars < COUNT_CAP)
                n_chars++;
            if (in_prefix && code == bsd_pkg::CHAR_ONE)
            begin
                if (n_ones < COUNT_CAP)
                    n_ones++;
            end
            else
                in_prefix = 1'b0;
            d = digit_value(code[6:0]);
            if (d < 0)
                bad_seen = 1'b1;
            else
                fold_digit(d);
            if (!last_flag)
                return;

            // end of string: one failure byte or the full big-endian result
            strings_done++;
            if (bad_seen || overflowed || n_chars < MIN_LEN || n_chars > MAX_LEN ||
                n_ones + sig_count != N_BYTES)
            begin
                r = '{value: 8'h00, index: 5'd0, ok: 1'b0, last: 1'b1};
                add_expected(r);
                rejected++;
            end
            else
            begin
                for (int k = 0; k < N_BYTES; k++)
                begin
                    r.value = (k >= n_ones) ? acc[N_BYTES - 1 - k] : 8'h00;
                    r.index = 5'(k);
                    r.ok    = 1'b1;
                    r.last  = (k == N_BYTES - 1);
                    add_expected(r);
                end
                decoded++;
            end
            clear_string();
        endfunction

        function void match_byte(logic [bsd_pkg::OUT_DATA_W-1:0] data, logic ok_bit,
                                 logic last_bit);
            byte_result_t got;
            byte_result_t want;
            got.value = data[7:0];
            got.index = data[12:8];
            got.ok    = ok_bit;
            got.last  = last_bit;
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected byte: value %02h index %0d ok %0b last %0b",
                             got.value, got.index, got.ok, got.last);
                return;
            end
            want = expected_bytes.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("byte mismatch: expected %02h/%0d/%0b/%0b, got %02h/%0d/%0b/%0b",
                             want.value, want.index, want.ok, want.last,
                             got.value, got.index, got.ok, got.last);
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [bsd_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;   // char_code[7:0]
    logic                          s_axis_tlast = 1'b0; // last_char
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [bsd_pkg::OUT_DATA_W-1:0] m_axis_tdata;       // out_byte[7:0], byte_index[12:8]
    logic                          m_axis_tuser;        // ok
    logic                          m_axis_tlast;        // last_byte

    base58_board board;
    logic [7:0]  text[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_ask = 0;
    int          chars_queued = 0;
    int          decodable_no = 0;
    int          serial = 0;

    base58_string_decoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400_000;
        $display("simulation failed");
        $finish;
    end

    // add one character at the end of the string being built
    function automatic void append_char(logic [7:0] c);
        text.insert(text.size(), c);
    endfunction

    // base58 spelling of a 25-byte value, one '1' per leading zero byte
    function automatic void spell_value(logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] rest;
        int                 zeros;
        text.delete();
        rest = value;
        while (rest != '0)
        begin
            text.push_front(B58_ALPHABET[int'(rest % 58)]);
            rest = rest / 58;
        end
        zeros = 0;
        while (zeros < N_BYTES && value[VALUE_W - 1 - 8 * zeros -: 8] == 8'h00)
            zeros++;
        repeat (zeros) text.push_front(bsd_pkg::CHAR_ONE);
    endfunction

    // mostly full-size values, now and then a long run of leading zero bytes
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        int                 zeros;
        zeros = ($urandom_range(3) == 0) ? $urandom_range(N_BYTES - 1) : $urandom_range(1);
        for (int i = 0; i < N_BYTES; i++)
            v[8 * i +: 8] = (i >= N_BYTES - zeros) ? 8'h00 : 8'($urandom_range(255));
        return v;
    endfunction

    function automatic logic [7:0] random_mapped(bit skip_one);
        return B58_ALPHABET[$urandom_range(57, skip_one ? 1 : 0)];
    endfunction

    function automatic logic [7:0] unmapped_code();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (base58_board::digit_value(c[6:0]) >= 0);
        return c;
    endfunction

    // three in eight strings well-formed, the rest broken, reshaped or noise
    function automatic text_kind_e kind_for(int n);
        case (n % 8)
            0, 6:    return TXT_DECODABLE;
            1:       return TXT_NOISE;
            2:       return TXT_OVERFLOW;
            3:       return TXT_CORRUPT;
            4:       return TXT_HIGH_BIT;
            5:       return TXT_OVERLONG;
            default: return TXT_RESHAPED;
        endcase
    endfunction

    task automatic build_text(input text_kind_e kind);
        int n;
        int pos;
        case (kind)
            TXT_DECODABLE:
            begin
                // an all-zero and an all-ones value start every run of four
                case (decodable_no % 4)
                    0:       spell_value('0);
                    1:       spell_value('1);
                    default: spell_value(random_value());
                endcase
                decodable_no++;
            end
            TXT_HIGH_BIT:
            begin
                // top bit set on digits past the leading ones keeps it valid
                spell_value(random_value());
                pos = 0;
                while (pos < text.size() && text[pos] == bsd_pkg::CHAR_ONE)
                    pos++;
                for (int i = pos; i < text.size(); i++)
                    if ($urandom_range(1) == 1)
                        text[i] = text[i] | 8'h80;
            end
            TXT_CORRUPT:
            begin
                spell_value(random_value());
                text[$urandom_range(text.size() - 1)] = unmapped_code();
            end
            TXT_RESHAPED:
            begin
                spell_value(random_value());
                case ($urandom_range(2))
                    0:       void'(text.pop_back());
                    1:       append_char(random_mapped(1'b0));
                    default: text.push_front(ONE_WITH_HIGH_BIT);
                endcase
            end
            TXT_OVERFLOW:
            begin
                text.delete();
                n = $urandom_range(MAX_LEN, OVERFLOW_LEN);
                append_char(random_mapped(1'b1));
                repeat (n - 1) append_char(random_mapped(1'b0));
            end
            TXT_OVERLONG:
            begin
                // counters saturate past the length limit
                text.delete();
                n = $urandom_range(MAX_LEN + 10, MAX_LEN);
                repeat (n) append_char(bsd_pkg::CHAR_ONE);
            end
            default:
            begin
                text.delete();
                n = $urandom_range(8, 1);
                repeat (n) append_char(8'($urandom_range(255)));
            end
        endcase
    endtask

    // one request on the input side, with random gaps before it
    task automatic send_char(input logic [7:0] code, input logic last_flag);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        s_axis_tlast  <= last_flag;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_text();
        for (int i = 0; i < text.size(); i++)
            send_char(text[i], i == text.size() - 1);
        chars_queued += text.size();
    endtask

    task automatic run_phase(input int target);
        while (chars_queued < target)
        begin
            build_text(kind_for(serial));
            serial++;
            send_text();
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // watch both sides and drive the output ready
    initial
    begin : stream_monitor
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (s_axis_tvalid && s_axis_tready)
                    board.take_char(s_axis_tdata, s_axis_tlast);
                if (m_axis_tvalid && m_axis_tready)
                    board.match_byte(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            if (hold_ask != 0)
            begin
                hold_left = hold_ask;
                hold_ask  = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        board = new();
        send_idle_pct = 12;
        recv_idle_pct = 83;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short directed strings: unmapped codes, length limits, high-bit one
        text = '{8'h00};
        send_text();
        text = '{8'hFF};
        send_text();
        text = '{8'h80, 8'h7F};
        send_text();
        text = '{bsd_pkg::CHAR_ONE, bsd_pkg::CHAR_ONE, bsd_pkg::CHAR_ONE,
                 bsd_pkg::CHAR_ONE, bsd_pkg::CHAR_ONE};
        send_text();
        text = '{ONE_WITH_HIGH_BIT, bsd_pkg::CHAR_ONE, 8'h32, 8'h7A};
        send_text();
        text = '{8'h7A, 8'h7A, 8'h7A, 8'h7A, 8'h7A};
        send_text();

        // slow receiver
        run_phase(115);
        wait_drained();

        // slow sender
        send_idle_pct = 83;
        recv_idle_pct = 12;
        run_phase(215);
        wait_drained();

        // no idling; a long receiver hold while short strings fill the block
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_ask = LONG_HOLD;
        repeat (8)
        begin
            text = '{8'($urandom_range(255))};
            send_text();
        end
        build_text(TXT_DECODABLE);
        send_text();
        run_phase(310);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d strings of %0d characters: %0d decoded to 25 bytes, %0d rejected",
                 board.strings_done, chars_queued, board.decoded, board.rejected);
        $display("%0d mismatches, %0d bytes never delivered",
                 board.mismatches, board.pending());
        if (board.mismatches == 0 && board.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bsd_pkg.sv
rtl/bsd_front.sv
rtl/bsd_queue.sv
rtl/bsd_back.sv
rtl/base58_string_decoder_unit.sv
tb/sv/base58_string_decoder_unit_test.sv
